[hw/rtl/iptcdf_pkg.sv]
// Package with the phase and event codes and the fixed sizes of the dataset deframer.
package iptcdf_pkg;

  // Most extended length bytes that a header may announce.
  localparam int unsigned MaxLengthBytes = 4;

  // Width of the length-byte counter; it must hold MaxLengthBytes.
  localparam int unsigned LenLeftW = $clog2(MaxLengthBytes + 1);

  // Configuration register indexes.
  localparam logic CfgMarker = 1'b0;
  localparam logic CfgBlockLen = 1'b1;

  // Reset value of the marker register.
  localparam logic [7:0] MarkerReset = 8'd28;

  // Header parse phases.
  typedef enum logic [2:0] {
    PH_SCAN    = 3'd0,
    PH_REC     = 3'd1,
    PH_DSET    = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_EXT     = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_DONE    = 3'd7
  } phase_e;

  // Result kinds.
  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_SKIP    = 2'd2,
    EV_ABORT   = 2'd3
  } event_kind_e;

  // One result item.
  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  record_number;
    logic [7:0]  dataset_number;
    logic [7:0]  payload_byte;
    logic [31:0] payload_length;
    logic        last;
  } result_t;

endpackage

[hw/rtl/iptc_dataset_deframer_core.sv]
// Byte-serial deframer for dataset headers of a block with configured length.
//
// The block takes one byte per cycle and gives at most one result per byte, so it
// sustains one request per cycle in both directions while results are taken. Each
// byte goes straight through the header state machine and its position and length
// counters into the output register; a new byte is taken whenever that register is
// empty or being drained in the same cycle. The one long path is the fit check of a
// header, one 34-bit add and compare of position plus declared length against the
// block length. Writing the block length register starts a new block; the user must
// write configuration only while no result is pending; the block does not check it.
module iptc_dataset_deframer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [31:0]                cfg_data_i,
  // Input byte channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 event_kind_o,
  output logic [7:0]                 record_number_o,
  output logic [7:0]                 dataset_number_o,
  output logic [7:0]                 payload_byte_o,
  output logic [31:0]                payload_length_o,
  output logic                       last_of_dataset_o
);
  import iptcdf_pkg::*;

  // Configuration and parse state.
  logic [7:0]          marker_q;
  logic [31:0]         block_len_q;
  phase_e              phase_q, phase_d;
  logic [31:0]         pos_q, pos_d;
  logic [7:0]          rec_q, rec_d;
  logic [7:0]          dset_q, dset_d;
  logic [31:0]         len_acc_q, len_acc_d;
  logic [LenLeftW-1:0] len_left_q, len_left_d;
  logic [31:0]         pay_left_q, pay_left_d;

  // Output register.
  logic                out_valid_q;
  result_t             res_q;

  // Step results.
  logic                res_valid;
  result_t             res;
  logic                in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Next parse state and the result that the current byte causes.
  always_comb begin
    logic [32:0] pos_p3;
    logic [33:0] hdr_end;
    logic [31:0] fin_len;
    logic [14:0] ext_count;
    logic [31:0] pay_dec;
    logic        do_finish;
    logic        advance;

    phase_d    = phase_q;
    pos_d      = pos_q;
    rec_d      = rec_q;
    dset_d     = dset_q;
    len_acc_d  = len_acc_q;
    len_left_d = len_left_q;
    pay_left_d = pay_left_q;
    res_valid  = 1'b0;
    res        = '{kind: EV_START, record_number: rec_q, dataset_number: dset_q,
                   payload_byte: 8'd0, payload_length: 32'd0, last: 1'b0};
    do_finish  = 1'b0;
    fin_len    = 32'd0;
    advance    = 1'b1;
    pos_p3     = {1'b0, pos_q} + 33'd3;
    ext_count  = {len_acc_q[6:0], data_byte_i};
    pay_dec    = pay_left_q - 32'd1;

    case (phase_q)
      PH_SCAN: begin
        if (pos_p3 >= {1'b0, block_len_q}) begin
          phase_d = PH_DONE;
          advance = 1'b0;
        end else if (data_byte_i == marker_q) begin
          phase_d = PH_REC;
        end
      end
      PH_REC: begin
        rec_d   = data_byte_i;
        phase_d = PH_DSET;
      end
      PH_DSET: begin
        dset_d  = data_byte_i;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_acc_d = {24'd0, data_byte_i};
        phase_d   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (pos_q >= block_len_q) begin
          phase_d = PH_DONE;
          advance = 1'b0;
        end else if (len_acc_q[7]) begin
          // Extended form: the low 15 bits count further length bytes.
          if (ext_count > 15'(MaxLengthBytes)) begin
            res_valid = 1'b1;
            res.kind  = EV_ABORT;
            phase_d   = PH_DONE;
            advance   = 1'b0;
          end else begin
            len_acc_d  = 32'd0;
            len_left_d = LenLeftW'(ext_count);
            if (ext_count == 15'd0) begin
              do_finish = 1'b1;
              fin_len   = 32'd0;
            end else begin
              phase_d = PH_EXT;
            end
          end
        end else begin
          len_acc_d = {len_acc_q[23:0], data_byte_i};
          do_finish = 1'b1;
          fin_len   = {len_acc_q[23:0], data_byte_i};
        end
      end
      PH_EXT: begin
        if (pos_q >= block_len_q) begin
          phase_d = PH_DONE;
          advance = 1'b0;
        end else begin
          len_acc_d  = {len_acc_q[23:0], data_byte_i};
          len_left_d = len_left_q - LenLeftW'(1);
          if (len_left_q == LenLeftW'(1)) begin
            do_finish = 1'b1;
            fin_len   = {len_acc_q[23:0], data_byte_i};
          end
        end
      end
      PH_PAYLOAD: begin
        pay_left_d       = pay_dec;
        res_valid        = 1'b1;
        res.kind         = EV_PAYLOAD;
        res.payload_byte = data_byte_i;
        res.last         = (pay_dec == 32'd0);
        if (pay_dec == 32'd0) begin
          phase_d = PH_SCAN;
        end
      end
      default: begin
        // Block finished: bytes are dropped until the block length is written.
        advance = 1'b0;
      end
    endcase

    // Header complete: start the dataset if it fits, else skip the block.
    hdr_end = {2'b0, pos_q} + 34'd1 + {2'b0, fin_len};
    if (do_finish) begin
      res_valid          = 1'b1;
      res.payload_length = fin_len;
      if (hdr_end <= {2'b0, block_len_q}) begin
        res.kind   = EV_START;
        res.last   = (fin_len == 32'd0);
        pay_left_d = fin_len;
        phase_d    = (fin_len == 32'd0) ? PH_SCAN : PH_PAYLOAD;
      end else begin
        res.kind = EV_SKIP;
        phase_d  = PH_DONE;
      end
    end

    // Byte position saturates at its top value.
    if (advance && (pos_q != '1)) begin
      pos_d = pos_q + 32'd1;
    end
  end

  // Configuration and parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q    <= MarkerReset;
      block_len_q <= 32'd0;
      phase_q     <= PH_SCAN;
      pos_q       <= 32'd0;
      rec_q       <= 8'd0;
      dset_q      <= 8'd0;
      len_acc_q   <= 32'd0;
      len_left_q  <= '0;
      pay_left_q  <= 32'd0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgMarker) begin
        marker_q <= cfg_data_i[7:0];
      end else begin
        // A new block length restarts the parse.
        block_len_q <= cfg_data_i;
        phase_q     <= PH_SCAN;
        pos_q       <= 32'd0;
        rec_q       <= 8'd0;
        dset_q      <= 8'd0;
        len_acc_q   <= 32'd0;
        len_left_q  <= '0;
        pay_left_q  <= 32'd0;
      end
    end else if (in_fire) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      rec_q      <= rec_d;
      dset_q     <= dset_d;
      len_acc_q  <= len_acc_d;
      len_left_q <= len_left_d;
      pay_left_q <= pay_left_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_kind_o      = res_q.kind;
  assign record_number_o   = res_q.record_number;
  assign dataset_number_o  = res_q.dataset_number;
  assign payload_byte_o    = res_q.payload_byte;
  assign payload_length_o  = res_q.payload_length;
  assign last_of_dataset_o = res_q.last;

  // A skipped or aborted dataset ends the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_we_i && res_valid && (res.kind == EV_SKIP || res.kind == EV_ABORT))
      |=> phase_q == PH_DONE)
    else $error("skip or abort did not end the block");

  // The last payload byte returns the parser to scanning.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_we_i && res_valid && res.kind == EV_PAYLOAD && res.last)
      |=> phase_q == PH_SCAN)
    else $error("last payload byte did not return to scanning");

  // Extended length phase always has between one and the maximum bytes left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EXT) |->
      (len_left_q != '0 && len_left_q <= LenLeftW'(MaxLengthBytes)))
    else $error("length byte counter out of range");

  // Payload phase always has at least one byte left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (pay_left_q != 32'd0))
    else $error("payload phase with nothing left");

  // A finished block produces no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_we_i && phase_q == PH_DONE) |=> !out_valid_q)
    else $error("result produced after the block end");

endmodule

[tb/iptc_dataset_deframer_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the dataset deframer core with a byte-level predictor.
module iptc_dataset_deframer_core_tb;
  import iptcdf_pkg::*;

  // A generous cycle budget for the whole run.
  localparam int unsigned CycleLimit = 800000;
  // Bytes inside blocks to send in the random part.
  localparam int unsigned RandomBytes = 1200;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  event_kind_o;
  logic [7:0]  record_number_o;
  logic [7:0]  dataset_number_o;
  logic [7:0]  payload_byte_o;
  logic [31:0] payload_length_o;
  logic        last_of_dataset_o;

  iptc_dataset_deframer_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_o     (event_kind_o),
    .record_number_o  (record_number_o),
    .dataset_number_o (dataset_number_o),
    .payload_byte_o   (payload_byte_o),
    .payload_length_o (payload_length_o),
    .last_of_dataset_o(last_of_dataset_o)
  );

  // Predictor copy of the configuration and the parse state.
  logic [7:0]  marker_reg;
  logic [31:0] block_len_reg;
  phase_e      cur_phase;
  logic [31:0] cur_pos;
  logic [7:0]  hdr_record;
  logic [7:0]  hdr_dataset;
  logic [31:0] len_val;
  logic [2:0]  ext_left;
  logic [31:0] pay_remaining;

  // Events still owed by the block, and bytes waiting to be sent.
  result_t     owed_events[$];
  logic [7:0]  byte_feed[$];
  logic [7:0]  block_bytes[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned blocks_run;
  int unsigned block_bytes_sent;
  int unsigned bytes_taken;
  int unsigned feed_gap;
  int unsigned stall_left;
  int unsigned kind_seen[4];
  bit          no_idle;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void restart_block();
    cur_phase     = PH_SCAN;
    cur_pos       = '0;
    hdr_record    = '0;
    hdr_dataset   = '0;
    len_val       = '0;
    ext_left      = '0;
    pay_remaining = '0;
  endfunction

  function automatic void add_event(event_kind_e kind, logic [7:0] pbyte,
                                    logic [31:0] plen, logic last);
    result_t r;
    r.kind           = kind;
    r.record_number  = hdr_record;
    r.dataset_number = hdr_dataset;
    r.payload_byte   = pbyte;
    r.payload_length = plen;
    r.last           = last;
    owed_events.push_back(r);
  endfunction

  // The header is complete: the dataset either fits in the block or is skipped.
  function automatic void close_header();
    logic [33:0] hdr_end;
    hdr_end = {2'b0, cur_pos} + 34'd1 + {2'b0, len_val};
    if (hdr_end <= {2'b0, block_len_reg}) begin
      add_event(EV_START, 8'd0, len_val, len_val == 32'd0);
      pay_remaining = len_val;
      cur_phase = (len_val == 32'd0) ? PH_SCAN : PH_PAYLOAD;
    end else begin
      add_event(EV_SKIP, 8'd0, len_val, 1'b0);
      cur_phase = PH_DONE;
    end
  endfunction

  // Advance the parse by one accepted byte and queue the event it causes.
  function automatic void deframe_byte(logic [7:0] b);
    logic [14:0] count;
    logic        stop;
    stop  = 1'b0;
    count = {len_val[6:0], b};
    case (cur_phase)
      PH_SCAN: begin
        // A marker needs three more bytes of the block behind it.
        if ({2'b0, cur_pos} + 34'd3 >= {2'b0, block_len_reg}) begin
          cur_phase = PH_DONE;
          stop = 1'b1;
        end else if (b == marker_reg) begin
          cur_phase = PH_REC;
        end
      end
      PH_REC: begin
        hdr_record = b;
        cur_phase  = PH_DSET;
      end
      PH_DSET: begin
        hdr_dataset = b;
        cur_phase   = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_val   = {24'd0, b};
        cur_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (cur_pos >= block_len_reg) begin
          cur_phase = PH_DONE;
          stop = 1'b1;
        end else if (len_val[7]) begin
          // Extended form: the low 15 bits count further length bytes.
          if (count > MaxLengthBytes) begin
            add_event(EV_ABORT, 8'd0, 32'd0, 1'b0);
            cur_phase = PH_DONE;
            stop = 1'b1;
          end else begin
            len_val  = '0;
            ext_left = count[2:0];
            if (count == 15'd0) close_header();
            else cur_phase = PH_EXT;
          end
        end else begin
          len_val = {len_val[23:0], b};
          close_header();
        end
      end
      PH_EXT: begin
        if (cur_pos >= block_len_reg) begin
          cur_phase = PH_DONE;
          stop = 1'b1;
        end else begin
          len_val  = {len_val[23:0], b};
          ext_left = ext_left - 3'd1;
          if (ext_left == 3'd0) close_header();
        end
      end
      PH_PAYLOAD: begin
        pay_remaining = pay_remaining - 32'd1;
        add_event(EV_PAYLOAD, b, 32'd0, pay_remaining == 32'd0);
        if (pay_remaining == 32'd0) cur_phase = PH_SCAN;
      end
      default: begin
        stop = 1'b1;
      end
    endcase
    if (!stop && cur_pos != 32'hFFFF_FFFF) cur_pos = cur_pos + 32'd1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Byte driver: holds each request until it is taken, then waits a random gap.
  always @(posedge clk_i) begin : byte_driver
    logic drive_valid;
    drive_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        deframe_byte(data_byte_i);
        bytes_taken++;
        drive_valid = 1'b0;
      end
      if (!drive_valid) begin
        if (feed_gap > 0) begin
          feed_gap--;
        end else if (byte_feed.size() > 0) begin
          data_byte_i <= byte_feed.pop_front();
          drive_valid = 1'b1;
          feed_gap = next_gap();
        end
      end
    end
    in_valid_i <= drive_valid;
  end

  // Event monitor: checks each accepted event and stalls the result side at random.
  always @(posedge clk_i) begin : event_monitor
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      kind_seen[event_kind_o]++;
      if (owed_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual kind %0d rec 0x%0h ds 0x%0h",
                 $time, event_kind_o, record_number_o, dataset_number_o);
        errors++;
      end else begin
        want = owed_events.pop_front();
        check_field("event_kind", 32'(want.kind), 32'(event_kind_o));
        check_field("record_number", 32'(want.record_number), 32'(record_number_o));
        check_field("dataset_number", 32'(want.dataset_number), 32'(dataset_number_o));
        check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte_o));
        check_field("payload_length", want.payload_length, payload_length_o);
        check_field("last_of_dataset", 32'(want.last), 32'(last_of_dataset_o));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = next_gap();
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d events owed", cycles, owed_events.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Wait until every byte is sent and every owed event has come out.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (byte_feed.size() != 0 || in_valid_i || owed_events.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the marker if asked, then the block length, which opens a new block.
  task automatic start_block(input bit set_marker, input logic [7:0] mk,
                             input logic [31:0] blen);
    wait_idle();
    if (set_marker) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CfgMarker;
      cfg_data_i  <= {24'd0, mk};
      @(posedge clk_i);
      marker_reg = mk;
    end
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgBlockLen;
    cfg_data_i  <= blen;
    @(posedge clk_i);
    block_len_reg = blen;
    restart_block();
    cfg_we_i <= 1'b0;
    blocks_run++;
  endtask

  // Marker, record, dataset and a length field; ext < 0 picks the 16-bit form.
  task automatic push_header(input logic [7:0] mk, input logic [31:0] len, input int ext);
    block_bytes.push_back(mk);
    block_bytes.push_back(8'($urandom));
    block_bytes.push_back(8'($urandom));
    if (ext < 0) begin
      block_bytes.push_back(len[15:8]);
      block_bytes.push_back(len[7:0]);
    end else begin
      block_bytes.push_back(8'h80);
      block_bytes.push_back(8'(ext));
      for (int i = ext - 1; i >= 0; i--) block_bytes.push_back(len[8*i +: 8]);
    end
  endtask

  // One random block: mostly well-formed datasets, with oversize, bad counts and noise.
  task automatic random_block();
    int unsigned nsets;
    int unsigned mode;
    int unsigned pick;
    int unsigned cut;
    logic [31:0] len;
    logic [31:0] blen;
    logic [14:0] cnt;
    logic [7:0]  mk;
    logic [7:0]  b;
    bit          new_marker;
    int          ext;
    new_marker = ($urandom_range(0, 5) == 0);
    mk = marker_reg;
    if (new_marker) begin
      pick = $urandom_range(0, 3);
      mk = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
    end
    block_bytes.delete();
    nsets = $urandom_range(1, 4);
    for (int s = 0; s < nsets; s++) begin
      repeat ($urandom_range(0, 2)) begin
        do b = 8'($urandom); while (b == mk);
        block_bytes.push_back(b);
      end
      mode = $urandom_range(0, 99);
      ext  = int'($urandom_range(0, 5)) - 1;
      if (mode < 80) begin
        // Dataset that fits, with random payload.
        len = (mode < 6) ? $urandom_range(128, 300) : $urandom_range(0, 12);
        if (ext == 0) len = 0;
        if (ext == 1 && len > 255) len = 255;
        push_header(mk, len, ext);
        repeat (len) block_bytes.push_back(8'($urandom));
      end else if (mode < 90) begin
        // Declared length far beyond the block.
        if (ext < 1) begin
          ext = -1;
          len = $urandom_range(16, 32'h7FFF);
        end else begin
          len = $urandom;
          if (ext < 4) len = len & ((32'd1 << (8 * ext)) - 32'd1);
          len = len | 32'h10;
          if ($urandom_range(0, 3) == 0) len = (ext == 4) ? '1 : (32'd1 << (8 * ext)) - 32'd1;
        end
        push_header(mk, len, ext);
        repeat ($urandom_range(0, 3)) block_bytes.push_back(8'($urandom));
        break;
      end else if (mode < 95) begin
        // Length-byte count above the limit.
        cnt = 15'($urandom_range(MaxLengthBytes + 1, 15'h7FFF));
        block_bytes.push_back(mk);
        block_bytes.push_back(8'($urandom));
        block_bytes.push_back(8'($urandom));
        block_bytes.push_back({1'b1, cnt[14:8]});
        block_bytes.push_back(cnt[7:0]);
        break;
      end else begin
        repeat ($urandom_range(1, 6)) block_bytes.push_back(8'($urandom));
      end
    end
    // Tail bytes, often markers that sit too near the end.
    repeat ($urandom_range(0, 3))
      block_bytes.push_back($urandom_range(0, 1) ? mk : 8'($urandom));
    blen = 32'(block_bytes.size());
    pick = $urandom_range(0, 19);
    if (pick < 2 && blen > 0) begin
      cut  = (blen < 4) ? blen : 4;
      blen = blen - $urandom_range(1, cut);
    end else if (pick == 2) begin
      blen = $urandom_range(0, 3);
    end else if (pick == 3) begin
      blen = 32'hFFFF_FFFF;
    end
    no_idle = ($urandom_range(0, 7) == 0);
    start_block(new_marker, mk, blen);
    foreach (block_bytes[i]) byte_feed.push_back(block_bytes[i]);
    if (pick == 4 || pick == 5) begin
      repeat ($urandom_range(1, 3)) byte_feed.push_back(8'($urandom));
    end
    block_bytes_sent += (block_bytes.size() < blen) ? block_bytes.size() : blen;
  endtask

  // Reset, directed blocks, then random blocks until enough bytes went through.
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CfgMarker;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    data_byte_i      = '0;
    out_ready_i      = 1'b0;
    errors           = 0;
    cycles           = 0;
    blocks_run       = 0;
    block_bytes_sent = 0;
    bytes_taken      = 0;
    feed_gap         = 0;
    stall_left       = 0;
    no_idle          = 1'b0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    marker_reg       = MarkerReset;
    block_len_reg    = '0;
    restart_block();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty block: every byte is ignored.
    start_block(1'b1, 8'd28, 32'd0);
    byte_feed.push_back(8'd28);

    // Standard length with extreme record and payload values, then a marker too near the end.
    start_block(1'b0, 8'd0, 32'd8);
    byte_feed.push_back(8'h1C);
    byte_feed.push_back(8'hFF);
    byte_feed.push_back(8'h00);
    byte_feed.push_back(8'h00);
    byte_feed.push_back(8'h02);
    byte_feed.push_back(8'hFF);
    byte_feed.push_back(8'h00);
    byte_feed.push_back(8'h1C);

    // Marker 0xFF, extended form with no length bytes: a zero-length dataset.
    start_block(1'b1, 8'hFF, 32'd6);
    byte_feed.push_back(8'hFF);
    byte_feed.push_back(8'h01);
    byte_feed.push_back(8'h02);
    byte_feed.push_back(8'h80);
    byte_feed.push_back(8'h00);

    // Length-byte count of 0x7FFF aborts the block.
    start_block(1'b0, 8'd0, 32'd10);
    byte_feed.push_back(8'hFF);
    byte_feed.push_back(8'h03);
    byte_feed.push_back(8'h04);
    byte_feed.push_back(8'hFF);
    byte_feed.push_back(8'hFF);

    // Marker 0x00 in the largest block; a four-byte all-ones length is skipped.
    start_block(1'b1, 8'h00, 32'hFFFF_FFFF);
    byte_feed.push_back(8'h00);
    byte_feed.push_back(8'h05);
    byte_feed.push_back(8'h06);
    byte_feed.push_back(8'h80);
    byte_feed.push_back(8'h04);
    repeat (4) byte_feed.push_back(8'hFF);

    while (block_bytes_sent < RandomBytes) random_block();

    wait_idle();
    repeat (6) @(posedge clk_i);
    $display("Sent %0d blocks and %0d bytes in %0d cycles.", blocks_run, bytes_taken, cycles);
    $display("Events: %0d starts, %0d payload bytes, %0d skipped, %0d aborted.",
             kind_seen[EV_START], kind_seen[EV_PAYLOAD], kind_seen[EV_SKIP],
             kind_seen[EV_ABORT]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
